// ===== hw/rtl/hkrt_pkg.sv =====
// Shared constants, types and helper functions for the hall key rapid trigger block.
`default_nettype none

package hkrt_pkg;

    localparam int KEYS          = 20;
    localparam int TRAVEL_UNITS  = 320;
    localparam int RELEASE_FLOOR = 10;

    localparam int KEY_IDX_W  = $clog2(KEYS);
    localparam int KEY_W      = 5;
    localparam int KIND_W     = 2;
    localparam int ADC_W      = 12;
    localparam int POS_W      = 9;
    localparam int CODE_W     = 8;
    localparam int ZONE_W     = 8;
    localparam int REM_W      = ADC_W + $clog2(TRAVEL_UNITS + 1);
    localparam int DIV_STEPS  = POS_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam int S_TDATA_W  = 56;
    localparam int S_TUSER_W  = KIND_W;
    localparam int M_TDATA_W  = 24;

    localparam logic [ADC_W-1:0]  DEF_SPAN       = ADC_W'(200);
    localparam logic [ADC_W-1:0]  DEF_NOISE      = ADC_W'(60);
    localparam logic [POS_W-1:0]  DEF_ACTUATION  = POS_W'(120);
    localparam logic [POS_W-1:0]  DEF_HYSTERESIS = POS_W'(50);
    localparam logic [ZONE_W-1:0] DEF_TOP        = ZONE_W'(20);
    localparam logic [ZONE_W-1:0] DEF_BOTTOM     = ZONE_W'(10);

    localparam logic [CODE_W-1:0] CODE_MIN   = CODE_W'(1);
    localparam logic [CODE_W-1:0] CODE_MAX   = CODE_W'(30);
    localparam logic [POS_W-1:0]  CODE_SCALE = POS_W'(10);

    localparam logic [KIND_W-1:0] KIND_SAMPLE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CALIBRATE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SETTINGS  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_FLOOR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SPAN = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [ADC_W-1:0]  rest;
        logic [ADC_W-1:0]  span;
        logic              pressed;
        logic [POS_W-1:0]  anchor;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  actuation;
        logic [POS_W-1:0]  hysteresis;
        logic [ZONE_W-1:0] top;
        logic [ZONE_W-1:0] bottom;
    } key_state_t;

    function automatic key_state_t default_state(input logic [ADC_W-1:0] rest,
                                                 input logic [ADC_W-1:0] span);
        key_state_t ks;
        ks.rest       = rest;
        ks.span       = span;
        ks.pressed    = 1'b0;
        ks.anchor     = '0;
        ks.pos        = '0;
        ks.actuation  = DEF_ACTUATION;
        ks.hysteresis = DEF_HYSTERESIS;
        ks.top        = DEF_TOP;
        ks.bottom     = DEF_BOTTOM;
        return ks;
    endfunction

    function automatic logic [POS_W-1:0] clamp_tenths(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] c;
        c = code;
        if (c < CODE_MIN) c = CODE_MIN;
        if (c > CODE_MAX) c = CODE_MAX;
        return POS_W'(c) * CODE_SCALE;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hall_key_rapid_trigger.sv =====
// Per-key rapid trigger for magnetic keys with an iterative position divider.
//
// The slave stream takes one word per item: tuser carries the kind (sample,
// calibrate, write settings) and tdata the key, raw ADC value and settings
// codes. Each item yields exactly one word on the master stream with the
// key, its pressed flag, current position and rapid trigger anchor.
// A sample runs through a load state, nine steps of a shared restoring
// subtract-and-compare unit that forms dev*320/span one quotient bit per
// cycle, and a write-back state that registers the result word.
// All other items, samples with a zero span and samples for a key
// beyond the last skip the divider: the load state goes straight to
// write-back, which then returns the sequencer to idle. The next word is
// accepted once the sequencer is back in idle, even while the previous result
// still waits in the output register. If the receiver stalls, the sequencer
// holds in its write-back cycle until the output register frees up. Reset
// loads every key with the default settings, a resting level of zero and the
// default span, and sets the noise floor to 60 and the initial span to 200.
`default_nettype none

module hall_key_rapid_trigger (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [hkrt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hkrt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // key[4:0], raw[16:5], actuation_code[24:17], hysteresis_code[32:25],
    // top_code[40:33], bottom_code[48:41], zero fill[55:49]
    input  wire logic [hkrt_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind[1:0]
    input  wire logic [hkrt_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // key_out[4:0], pressed[5], position[14:6], anchor[23:15]
    output logic [hkrt_pkg::M_TDATA_W-1:0]       m_tdata
);
    import hkrt_pkg::*;

    state_t                 state_reg, state_next;
    logic [ADC_W-1:0]       noise_floor_reg;
    logic [ADC_W-1:0]       initial_span_reg;
    key_state_t             keys_reg [KEYS];

    logic [KIND_W-1:0]      kind_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [ADC_W-1:0]       raw_reg;
    logic [CODE_W-1:0]      act_code_reg;
    logic [CODE_W-1:0]      hyst_code_reg;
    logic [CODE_W-1:0]      top_code_reg;
    logic [CODE_W-1:0]      bottom_code_reg;

    logic [ADC_W-1:0]       span_reg, span_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [POS_W-1:0]       quot_reg, quot_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic                   accept;
    logic                   key_ok;
    logic [KEY_IDX_W-1:0]   idx;
    key_state_t             ks;
    key_state_t             ks_new;
    logic                   key_we;
    logic [ADC_W-1:0]       dev_abs;
    logic [ADC_W-1:0]       dev;
    logic [REM_W-1:0]       trial;
    logic [POS_W-1:0]       pos_div;
    logic [POS_W-1:0]       pos;
    logic [POS_W:0]         a_plus_h;
    logic [POS_W:0]         p_plus_h;
    logic                   in_bottom;
    logic                   out_free;

    assign accept   = s_tvalid && s_tready;
    assign key_ok   = int'(key_reg) < KEYS;
    assign idx      = key_reg[KEY_IDX_W-1:0];
    assign ks       = keys_reg[idx];
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign dev_abs = (raw_reg >= ks.rest) ? (raw_reg - ks.rest) : (ks.rest - raw_reg);
    assign dev     = (dev_abs < noise_floor_reg) ? '0 : dev_abs;
    assign trial   = REM_W'(span_reg) << cnt_reg;

    assign pos_div   = (quot_reg > POS_W'(TRAVEL_UNITS)) ? POS_W'(TRAVEL_UNITS) : quot_reg;
    assign pos       = (pos_div < POS_W'(ks.top)) ? '0 : pos_div;
    assign a_plus_h  = {1'b0, ks.anchor} + {1'b0, ks.hysteresis};
    assign p_plus_h  = {1'b0, pos} + {1'b0, ks.hysteresis};
    assign in_bottom = ({1'b0, pos} + (POS_W+1)'(ks.bottom)) > (POS_W+1)'(TRAVEL_UNITS);

    always_comb
    begin
        state_next    = state_reg;
        span_next     = span_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        ks_new        = ks;
        key_we        = 1'b0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                span_next = (dev > ks.span) ? dev : ks.span;
                rem_next  = REM_W'(dev) * REM_W'(TRAVEL_UNITS);
                quot_next = '0;
                cnt_next  = CNT_W'(DIV_STEPS - 1);
                if (key_ok && kind_reg == KIND_SAMPLE && span_next != '0)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (rem_reg >= trial)
                begin
                    rem_next       = rem_reg - trial;
                    quot_next      = quot_reg;
                    quot_next[cnt_reg] = 1'b1;
                end
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                case (kind_reg)
                    KIND_SAMPLE:
                    begin
                        ks_new.span = span_reg;
                        ks_new.pos  = pos;
                        if (ks.pressed)
                        begin
                            if (p_plus_h < {1'b0, ks.anchor})
                            begin
                                if (!in_bottom)
                                begin
                                    ks_new.pressed = 1'b0;
                                end
                                ks_new.anchor = pos;
                            end
                            else if (pos > ks.anchor)
                            begin
                                ks_new.anchor = pos;
                            end
                            if (pos <= POS_W'(RELEASE_FLOOR))
                            begin
                                ks_new.pressed = 1'b0;
                            end
                        end
                        else
                        begin
                            if ({1'b0, pos} > a_plus_h && pos >= ks.actuation)
                            begin
                                ks_new.pressed = 1'b1;
                                ks_new.anchor  = pos;
                            end
                            else if (pos < ks.anchor)
                            begin
                                ks_new.anchor = pos;
                            end
                        end
                    end
                    KIND_CALIBRATE:
                    begin
                        ks_new = default_state(raw_reg, initial_span_reg);
                    end
                    KIND_SETTINGS:
                    begin
                        ks_new.actuation  = clamp_tenths(act_code_reg);
                        ks_new.hysteresis = clamp_tenths(hyst_code_reg);
                        ks_new.top        = top_code_reg;
                        ks_new.bottom     = bottom_code_reg;
                    end
                    default:
                    begin
                        ks_new = ks;
                    end
                endcase

                if (out_free)
                begin
                    key_we        = key_ok;
                    m_tvalid_next = 1'b1;
                    if (key_ok)
                    begin
                        m_tdata_next = {ks_new.anchor, ks_new.pos, ks_new.pressed, key_reg};
                    end
                    else
                    begin
                        m_tdata_next = {{(M_TDATA_W-KEY_W){1'b0}}, key_reg};
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_floor_reg  <= DEF_NOISE;
            initial_span_reg <= DEF_SPAN;
            m_tvalid_reg     <= 1'b0;
            for (int k = 0; k < KEYS; k++)
            begin
                keys_reg[k] <= default_state('0, DEF_SPAN);
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NOISE_FLOOR:  noise_floor_reg  <= cfg_data;
                    CFG_INITIAL_SPAN: initial_span_reg <= cfg_data;
                    default:          noise_floor_reg  <= noise_floor_reg;
                endcase
            end
            m_tvalid_reg <= m_tvalid_next;
            if (key_we)
            begin
                keys_reg[idx] <= ks_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg        <= s_tuser[KIND_W-1:0];
            key_reg         <= s_tdata[4:0];
            raw_reg         <= s_tdata[16:5];
            act_code_reg    <= s_tdata[24:17];
            hyst_code_reg   <= s_tdata[32:25];
            top_code_reg    <= s_tdata[40:33];
            bottom_code_reg <= s_tdata[48:41];
        end
        span_reg    <= span_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        cnt_reg     <= cnt_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef ASSERT_OFF
    // A pressed key always sits above the forced release floor.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[5] |-> m_tdata[14:6] > POS_W'(RELEASE_FLOOR))
        else $error("pressed key reported at or below the release floor");

    // Position and anchor never leave the travel range.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[14:6] <= POS_W'(TRAVEL_UNITS)
                  && m_tdata[23:15] <= POS_W'(TRAVEL_UNITS))
        else $error("position or anchor beyond full travel");

    // The divider only runs on a nonzero span.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> span_reg != '0)
        else $error("divider started with a zero span");

    // A finished item leaves a valid result word behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && state_next == ST_IDLE |=> m_tvalid)
        else $error("item finished without a result word");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking stream testbench for the hall key rapid trigger block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hkrt_pkg::*;

    localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [ADC_W-1:0]  raw;
        logic [CODE_W-1:0] act;
        logic [CODE_W-1:0] hys;
        logic [CODE_W-1:0] top;
        logic [CODE_W-1:0] bot;
    } key_item_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             pressed;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] anchor;
    } key_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;

    hall_key_rapid_trigger dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Predictor state: one entry per key plus the two register copies.
    int noise_cfg;
    int span_cfg;
    int rest_lvl[KEYS];
    int span_pk[KEYS];
    bit prs[KEYS];
    int anch[KEYS];
    int cur[KEYS];
    int act_pos[KEYS];
    int hys_d[KEYS];
    int top_z[KEYS];
    int bot_z[KEYS];

    key_item_t   pending_q[$];
    key_result_t key_result_q[$];

    int  n_queued;
    int  n_accepted;
    int  n_checked;
    int  n_errors;
    int  n_presses;
    int  cycles;
    int  gap_pct;
    int  stall_pct;
    bit  word_taken;
    bit  hold_go;
    bit  rx_hold;

    function automatic void restore_key(int k, int rest, int span);
        rest_lvl[k] = rest;
        span_pk[k]  = span;
        prs[k]      = 1'b0;
        anch[k]     = 0;
        cur[k]      = 0;
        act_pos[k]  = 120;
        hys_d[k]    = 50;
        top_z[k]    = 20;
        bot_z[k]    = 10;
    endfunction

    function automatic int tenths_of(logic [CODE_W-1:0] code);
        int c;
        c = code;
        if (c < 1) c = 1;
        if (c > 30) c = 30;
        return c * 10;
    endfunction

    function automatic key_result_t predict_key_event(key_item_t it);
        key_result_t r;
        int k;
        int dev;
        int p;
        int a;
        int h;
        bit in_bottom;
        r.key      = it.key;
        r.pressed  = 1'b0;
        r.position = '0;
        r.anchor   = '0;
        k = it.key;
        if (k >= KEYS) return r;
        if (it.kind == KIND_SAMPLE)
        begin
            dev = (it.raw >= rest_lvl[k]) ? it.raw - rest_lvl[k] : rest_lvl[k] - it.raw;
            if (dev < noise_cfg) dev = 0;
            if (dev > span_pk[k]) span_pk[k] = dev;
            if (span_pk[k] == 0)
                p = 0;
            else
                p = (dev * TRAVEL_UNITS) / span_pk[k];
            if (p > TRAVEL_UNITS) p = TRAVEL_UNITS;
            if (p < top_z[k]) p = 0;
            cur[k] = p;
            a = anch[k];
            h = hys_d[k];
            if (prs[k])
            begin
                in_bottom = p > (TRAVEL_UNITS - bot_z[k]);
                if (p < a - h)
                begin
                    if (!in_bottom) prs[k] = 1'b0;
                    anch[k] = p;
                end
                else if (p > a)
                    anch[k] = p;
                if (p <= RELEASE_FLOOR) prs[k] = 1'b0;
            end
            else
            begin
                if (p > a + h && p >= act_pos[k])
                begin
                    prs[k]  = 1'b1;
                    anch[k] = p;
                    n_presses++;
                end
                else if (p < a)
                    anch[k] = p;
            end
        end
        else if (it.kind == KIND_CALIBRATE)
            restore_key(k, it.raw, span_cfg);
        else if (it.kind == KIND_SETTINGS)
        begin
            act_pos[k] = tenths_of(it.act);
            hys_d[k]   = tenths_of(it.hys);
            top_z[k]   = it.top;
            bot_z[k]   = it.bot;
        end
        r.pressed  = prs[k];
        r.position = POS_W'(cur[k]);
        r.anchor   = POS_W'(anch[k]);
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin : watchdog
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Sender: holds a word until it is taken, then pulls the next one.
    always @(negedge clk)
    begin : drive_in
        key_item_t it;
        bit        keep;
        if (rst_n)
        begin
            keep = s_tvalid && !word_taken;
            if (!keep && pending_q.size() > 0 && $urandom_range(99) >= gap_pct)
            begin
                it = pending_q.pop_front();
                s_tuser <= it.kind;
                s_tdata <= {7'b0, it.bot, it.top, it.hys, it.act, it.raw, it.key};
                keep = 1'b1;
            end
            s_tvalid <= keep;
        end
    end

    always @(negedge clk)
    begin : drive_out
        if (rst_n)
            m_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);
    end

    initial
    begin : long_hold
        rx_hold = 1'b0;
        wait (hold_go);
        @(negedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk)
    begin : monitor
        key_item_t   it;
        key_result_t got;
        key_result_t want;
        if (rst_n)
        begin
            word_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                it.kind = s_tuser;
                it.key  = s_tdata[4:0];
                it.raw  = s_tdata[16:5];
                it.act  = s_tdata[24:17];
                it.hys  = s_tdata[32:25];
                it.top  = s_tdata[40:33];
                it.bot  = s_tdata[48:41];
                key_result_q.push_back(predict_key_event(it));
                n_accepted <= n_accepted + 1;
            end
            if (m_tvalid && m_tready)
            begin
                got.key      = m_tdata[4:0];
                got.pressed  = m_tdata[5];
                got.position = m_tdata[14:6];
                got.anchor   = m_tdata[23:15];
                if (key_result_q.size() == 0)
                begin
                    $error("unexpected result word %h", m_tdata);
                    n_errors++;
                end
                else
                begin
                    want = key_result_q.pop_front();
                    if (got.key !== want.key)
                    begin
                        $error("key_out: expected %0d, got %0d", want.key, got.key);
                        n_errors++;
                    end
                    if (got.pressed !== want.pressed)
                    begin
                        $error("pressed: expected %0d, got %0d", want.pressed, got.pressed);
                        n_errors++;
                    end
                    if (got.position !== want.position)
                    begin
                        $error("position: expected %0d, got %0d",
                               want.position, got.position);
                        n_errors++;
                    end
                    if (got.anchor !== want.anchor)
                    begin
                        $error("anchor: expected %0d, got %0d", want.anchor, got.anchor);
                        n_errors++;
                    end
                    n_checked <= n_checked + 1;
                end
            end
        end
    end

    task automatic add_item(logic [KIND_W-1:0] kind, int key, int raw,
                            int act = 0, int hys = 0, int top = 0, int bot = 0);
        key_item_t it;
        it.kind = kind;
        it.key  = KEY_W'(key);
        it.raw  = ADC_W'(raw);
        it.act  = CODE_W'(act);
        it.hys  = CODE_W'(hys);
        it.top  = CODE_W'(top);
        it.bot  = CODE_W'(bot);
        pending_q.push_back(it);
        n_queued++;
    endtask

    task automatic drain();
        wait (n_accepted == n_queued && n_checked == n_accepted);
        repeat (16) @(negedge clk);
    endtask

    task automatic load_regs(int noise, int span);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NOISE_FLOOR;
        cfg_data  <= CFG_DATA_W'(noise);
        @(negedge clk);
        cfg_index <= CFG_INITIAL_SPAN;
        cfg_data  <= CFG_DATA_W'(span);
        @(negedge clk);
        cfg_we    <= 1'b0;
        noise_cfg = noise;
        span_cfg  = span;
    endtask

    // Mostly press and release strokes, usually after a calibration, with some fully random words.
    task automatic add_strokes(int count);
        int added;
        int key;
        int rest;
        int peak;
        int npts;
        int half;
        int dev;
        int raw;
        bit up;
        added = 0;
        while (added < count)
        begin
            if ($urandom_range(99) < 20)
            begin
                add_item(KIND_W'($urandom_range(0, 3)), $urandom_range(0, 31),
                         $urandom_range(0, 4095),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255));
                added++;
            end
            else
            begin
                key  = $urandom_range(0, KEYS - 1);
                rest = $urandom_range(0, 4095);
                up   = $urandom_range(0, 1);
                if ($urandom_range(0, 3) != 0)
                begin
                    add_item(KIND_CALIBRATE, key, rest);
                    added++;
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    add_item(KIND_SETTINGS, key, $urandom_range(0, 4095),
                             ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(0, 31),
                             ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(0, 31),
                             ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(0, 40),
                             $urandom_range(0, 255));
                    added++;
                end
                peak = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                   : $urandom_range(40, 600);
                npts = $urandom_range(4, 14);
                half = npts / 2;
                for (int i = 0; i < npts; i++)
                begin
                    dev = (i <= half) ? peak * i / half : peak * (npts - i) / half;
                    dev = dev + $urandom_range(0, 30);
                    raw = up ? rest + dev : rest - dev;
                    if (raw < 0) raw = 0;
                    if (raw > 4095) raw = 4095;
                    add_item(KIND_SAMPLE, key, raw);
                    added++;
                end
            end
        end
    endtask

    task automatic run_phase(int gap, int stall, int count);
        gap_pct   = gap;
        stall_pct = stall;
        add_strokes(count);
        drain();
    endtask

    initial
    begin : stimulus
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        word_taken = 1'b0;
        hold_go    = 1'b0;
        gap_pct    = 0;
        stall_pct  = 0;
        cycles     = 0;
        n_queued   = 0;
        n_accepted = 0;
        n_checked  = 0;
        n_errors   = 0;
        n_presses  = 0;
        noise_cfg  = 60;
        span_cfg   = 200;
        for (int k = 0; k < KEYS; k++)
            restore_key(k, 0, 200);
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Uncalibrated keys, unused kind and keys beyond the last one.
        add_item(KIND_SAMPLE, 0, 0);
        add_item(KIND_SAMPLE, 1, 4095);
        add_item(KIND_NOP, 1, 0);
        add_item(KIND_SAMPLE, 20, 4095);
        add_item(KIND_SETTINGS, 31, 4095, 255, 255, 255, 255);
        add_item(KIND_CALIBRATE, 25, 100);
        add_item(KIND_NOP, 31, 4095);
        // Reading below the resting level and settings clamped at both ends.
        add_item(KIND_CALIBRATE, 2, 2000);
        add_item(KIND_SAMPLE, 2, 1700);
        add_item(KIND_SETTINGS, 2, 0, 0, 255, 0, 255);
        add_item(KIND_SETTINGS, 3, 0, 255, 0, 255, 0);
        add_item(KIND_SAMPLE, 3, 4095);
        add_item(KIND_SAMPLE, 3, 2500);
        // Noise floor, press, release on the way up and rapid re-press.
        add_item(KIND_CALIBRATE, 4, 1000);
        add_item(KIND_SAMPLE, 4, 1030);
        add_item(KIND_SAMPLE, 4, 1200);
        add_item(KIND_SAMPLE, 4, 1100);
        add_item(KIND_SAMPLE, 4, 1180);
        // Release held off inside the bottom deadzone.
        add_item(KIND_CALIBRATE, 5, 500);
        add_item(KIND_SETTINGS, 5, 0, 5, 1, 0, 255);
        add_item(KIND_SAMPLE, 5, 700);
        add_item(KIND_SAMPLE, 5, 650);
        add_item(KIND_SAMPLE, 5, 502);
        // Forced release near the top while the hysteresis alone would hold.
        add_item(KIND_SAMPLE, 7, 4095);
        add_item(KIND_SAMPLE, 7, 0);
        add_item(KIND_SETTINGS, 7, 0, 1, 1, 0, 0);
        add_item(KIND_SAMPLE, 7, 1000);
        add_item(KIND_SETTINGS, 7, 0, 1, 30, 0, 0);
        add_item(KIND_SAMPLE, 7, 100);
        drain();

        load_regs(60, 200);
        run_phase(0, 0, 150);
        load_regs(0, 4095);
        run_phase(83, 0, 130);
        load_regs(4095, 1);
        run_phase(0, 83, 130);
        load_regs(25, 0);
        run_phase(19, 19, 130);

        // Long receiver hold while the sender keeps offering words.
        load_regs($urandom_range(0, 200), $urandom_range(50, 1000));
        gap_pct   = 0;
        stall_pct = 0;
        hold_go   = 1'b1;
        add_strokes(60);
        drain();

        load_regs($urandom_range(0, 4095), $urandom_range(0, 4095));
        run_phase(19, 19, 100);

        $display("Checked %0d result words for %0d input words, %0d key presses seen,",
                 n_checked, n_accepted, n_presses);
        $display("across six register settings, four idle patterns and one long hold.");
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/hkrt_pkg.sv
hw/rtl/hall_key_rapid_trigger.sv
tb/sv/tb_top.sv
